/* hdl/itda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants of the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  // Number of value bits that take part in the conversion (8 to 64).
  localparam int VALUE_WIDTH = 64;

  // Decimal digits of the largest VALUE_WIDTH-bit number: floor(W*log10(2))+1.
  localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) / 4096) + 1;

  // Counter widths.
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

  // Widths of the stream payloads.
  localparam int IN_DATA_W  = 64;
  localparam int CHAR_W     = 6;
  localparam int OUT_DATA_W = 8;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  // Operation codes carried in tuser.
  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

  // One BCD digit.
  typedef logic [3:0] bcd_t;

  // Commands that drive every cell of the digit chain in the same cycle.
  typedef struct packed {
    logic clear;    // zero all digits
    logic convert;  // one shift-and-adjust step, new bit enters at the bottom
    logic shift;    // move every digit one cell toward the top
  } chain_ctrl_t;

endpackage

/* hdl/itda_digit_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_digit_cell
// One BCD digit of the conversion chain: shift-and-add-3 step or digit move.
// ----------------------------------------------------------------------------
module itda_digit_cell (
  input  logic                 clk,
  input  itda_pkg::chain_ctrl_t ctrl,
  input  logic                 carry_in,   // bit from the cell below
  input  itda_pkg::bcd_t       digit_in,   // digit of the cell below
  output logic                 carry_out,  // bit handed to the cell above
  output itda_pkg::bcd_t       digit       // digit held by this cell
);

  itda_pkg::bcd_t adjusted;

  // Add three before the shift when the digit would overflow past nine.
  assign adjusted  = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign carry_out = adjusted[3];

  // Digit register.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.convert) begin
      digit <= {adjusted[2:0], carry_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

/* hdl/itda_digit_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_digit_chain
// Row of BCD cells; cell 0 is the least significant digit.
// ----------------------------------------------------------------------------
module itda_digit_chain (
  input  logic                  clk,
  input  itda_pkg::chain_ctrl_t ctrl,
  input  logic                  bit_in,     // next magnitude bit, MSB first
  output itda_pkg::bcd_t        top_digit   // most significant digit
);

  logic           carry [itda_pkg::NUM_DIGITS+1];
  itda_pkg::bcd_t digits [itda_pkg::NUM_DIGITS+1];

  // The bottom cell takes the new bit while converting and a zero while moving.
  assign carry[0]  = bit_in;
  assign digits[0] = 4'd0;

  // Each cell sees the carry and digit of the one below it.
  for (genvar i = 0; i < itda_pkg::NUM_DIGITS; i++) begin : g_cell
    itda_digit_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .carry_in (carry[i]),
      .digit_in (digits[i]),
      .carry_out(carry[i+1]),
      .digit    (digits[i+1])
    );
  end

  assign top_digit = digits[itda_pkg::NUM_DIGITS];

endmodule

/* hdl/int_to_decimal_ascii_core.sv */
`timescale 1ns / 1ps
// Operation: a taken request runs VALUE_WIDTH conversion steps; then the leading
//   zero digits (0 to NUM_DIGITS-1 of them) are skipped, a minus sign goes out if
//   the value is negative, and one character leaves for each digit that is left,
//   each held while the receiver stalls. No new request is taken until the last
//   character of the previous text has been accepted.
// Reset: synchronous, active high; clears the control state, digits need none.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Converts a signed or unsigned integer to its decimal ASCII characters.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [itda_pkg::IN_DATA_W-1:0]   s_tdata,   // [63:0] value
  input  logic                             s_tuser,   // [0] op
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [itda_pkg::OUT_DATA_W-1:0]  m_tdata,   // [5:0] character, [7:6] zero
  output logic                             m_tlast    // last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                       state;
  logic [2:0]                       state_next;
  logic [itda_pkg::VALUE_WIDTH-1:0] mag;
  logic                             negative;
  logic [itda_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic [itda_pkg::DIG_CNT_W-1:0]   remaining;
  logic [itda_pkg::VALUE_WIDTH-1:0] raw;
  logic                             raw_neg;
  logic                             in_req;
  logic                             out_req;
  logic                             skip_zero;
  itda_pkg::chain_ctrl_t            ctrl;
  itda_pkg::bcd_t                   top_digit;
  logic [itda_pkg::CHAR_W-1:0]      character;

  // Input side: low value bits, sign detection in signed mode.
  assign raw      = s_tdata[itda_pkg::VALUE_WIDTH-1:0];
  assign raw_neg  = (s_tuser == itda_pkg::OP_SIGNED) && raw[itda_pkg::VALUE_WIDTH-1];
  assign s_tready = (state == ST_IDLE);
  assign in_req   = s_tvalid && s_tready;
  assign out_req  = m_tvalid && m_tready;

  // A leading zero is dropped unless it is the only digit left.
  assign skip_zero = (top_digit == 4'd0) && (remaining > itda_pkg::DIG_CNT_W'(1));

  // Chain commands.
  always_comb begin
    ctrl.clear   = in_req;
    ctrl.convert = (state == ST_CONV);
    ctrl.shift   = ((state == ST_SKIP) && skip_zero) || ((state == ST_EMIT) && out_req);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_req) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == '0) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!skip_zero) begin
          state_next = negative ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_req) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_req && (remaining == itda_pkg::DIG_CNT_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Magnitude shift register and counters.
  always_ff @(posedge clk) begin
    if (in_req) begin
      mag       <= raw_neg ? (~raw + itda_pkg::VALUE_WIDTH'(1)) : raw;
      negative  <= raw_neg;
      bit_cnt   <= itda_pkg::BIT_CNT_W'(itda_pkg::VALUE_WIDTH - 1);
      remaining <= itda_pkg::DIG_CNT_W'(itda_pkg::NUM_DIGITS);
    end else begin
      if (ctrl.convert) begin
        mag     <= {mag[itda_pkg::VALUE_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt - itda_pkg::BIT_CNT_W'(1);
      end
      if (ctrl.shift) begin
        remaining <= remaining - itda_pkg::DIG_CNT_W'(1);
      end
    end
  end

  // BCD cell row.
  itda_digit_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .bit_in   (mag[itda_pkg::VALUE_WIDTH-1]),
    .top_digit(top_digit)
  );

  // Output characters come straight from the state and the top digit.
  assign character = (state == ST_SIGN) ? itda_pkg::CHAR_MINUS
                                        : (itda_pkg::CHAR_ZERO + {2'b00, top_digit});
  assign m_tvalid  = (state == ST_SIGN) || (state == ST_EMIT);
  assign m_tdata   = {2'b00, character};
  assign m_tlast   = (state == ST_EMIT) && (remaining == itda_pkg::DIG_CNT_W'(1));

endmodule

/* hdl/itda_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_checker
// Port-level checks of the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
module itda_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [itda_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

  // One value at a time: no request is taken while characters are pending.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  // A taken request closes the input until its text is done.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a request");

  // Only a minus sign or a digit leaves the block.
  a_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata == {2'b00, itda_pkg::CHAR_MINUS}) ||
                  ((m_tdata >= {2'b00, itda_pkg::CHAR_ZERO}) &&
                   (m_tdata <= {2'b00, itda_pkg::CHAR_NINE}))))
    else $error("bad output character");

  // The minus sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata == {2'b00, itda_pkg::CHAR_MINUS})) |-> !m_tlast)
    else $error("minus sign marked last");

endmodule

bind int_to_decimal_ascii_core itda_checker u_itda_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

/* tb/int_to_decimal_ascii_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core_test
// Self-checking bench for the integer to decimal ASCII converter. Directed
// corner values and random values of many magnitudes are sent in signed and
// unsigned mode; every character that leaves the block is compared with the
// text predicted for the value, under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_core_test;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = itda_pkg::VALUE_WIDTH + itda_pkg::NUM_DIGITS + 16;
  localparam int RANDOM_PER_PHASE = 115;

  // One predicted character of the decimal text.
  typedef struct {
    logic [itda_pkg::CHAR_W-1:0] code;
    logic                        is_last;
  } text_char_t;

  // Predicts the decimal text of each request and checks the characters.
  class digit_scoreboard;
    text_char_t char_q[$];
    int mismatches;
    int values_seen;
    int signed_seen;
    int negative_seen;
    int chars_checked;
    int longest_text;

    function new();
      mismatches    = 0;
      values_seen   = 0;
      signed_seen   = 0;
      negative_seen = 0;
      chars_checked = 0;
      longest_text  = 0;
    endfunction

    // Work out the characters that one accepted request must produce.
    function void note_request(logic op, logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] raw;
      logic [63:0] mag;
      logic        negative;
      logic [3:0]  digits[$];
      text_char_t  c;
      int          n;
      mask     = {64{1'b1}} >> (64 - itda_pkg::VALUE_WIDTH);
      raw      = value & mask;
      negative = (op == itda_pkg::OP_SIGNED) && raw[itda_pkg::VALUE_WIDTH-1];
      mag      = negative ? (((~raw) + 64'd1) & mask) : raw;
      // Peel off digits least significant first, storing them in text order.
      do begin
        digits.push_front(4'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 64'd0);
      n = digits.size();
      if (negative) begin
        c.code    = itda_pkg::CHAR_MINUS;
        c.is_last = 1'b0;
        char_q.push_back(c);
        n++;
        negative_seen++;
      end
      foreach (digits[i]) begin
        c.code    = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(digits[i]);
        c.is_last = (i == digits.size() - 1);
        char_q.push_back(c);
      end
      values_seen++;
      if (op == itda_pkg::OP_SIGNED) signed_seen++;
      if (n > longest_text) longest_text = n;
    endfunction

    // Compare one accepted output character with the oldest prediction.
    function void check_char(logic [itda_pkg::OUT_DATA_W-1:0] data, logic tlast);
      text_char_t                      exp_c;
      logic [itda_pkg::OUT_DATA_W-1:0] exp_data;
      if (char_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected character data=0x%02h last=%0b", $time, data, tlast);
        return;
      end
      exp_c    = char_q.pop_front();
      exp_data = {{(itda_pkg::OUT_DATA_W-itda_pkg::CHAR_W){1'b0}}, exp_c.code};
      chars_checked++;
      if (data !== exp_data || tlast !== exp_c.is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] character mismatch: expected data=0x%02h last=%0b, %s",
                   $time, exp_data, exp_c.is_last,
                   $sformatf("got data=0x%02h last=%0b", data, tlast));
      end
    endfunction

    function int pending();
      return char_q.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [itda_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [itda_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tlast;

  digit_scoreboard sb;
  int src_idle_pct;
  int sink_idle_pct;
  int cycles = 0;

  int_to_decimal_ascii_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d characters outstanding.",
               CYCLE_LIMIT, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    if (rst) m_tready = 1'b0;
    else m_tready = ($urandom_range(99) >= sink_idle_pct);
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_char(m_tdata, m_tlast);
  end

  // Present one request, with random idle cycles ahead of it. Called and
  // returning at a falling edge; tvalid stays high for a following request.
  task automatic send_request(input logic op, input logic [63:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = value;
    s_tuser  = op;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, value);
    @(negedge clk);
  endtask

  // Hold the sender back until every predicted character has come out.
  task automatic drain_block();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Random values spread over all text lengths and around powers of ten.
  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    logic [63:0] p;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: pick_value = r;
      1: pick_value = r >> $urandom_range(63);
      2: begin
        p = 64'd1;
        repeat ($urandom_range(19)) p = p * 64'd10;
        pick_value = p + 64'($urandom_range(2)) - 64'd1;
      end
      default: pick_value = -(r >> $urandom_range(63));
    endcase
  endfunction

  initial begin
    sb = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = itda_pkg::OP_SIGNED;
    src_idle_pct  = 14;
    sink_idle_pct = 70;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed corners: zero, single digits, digit-count boundaries, the
    // signed extremes and the unsigned maximum.
    send_request(itda_pkg::OP_SIGNED,   64'd0);
    send_request(itda_pkg::OP_UNSIGNED, 64'd0);
    send_request(itda_pkg::OP_SIGNED,   64'd1);
    send_request(itda_pkg::OP_UNSIGNED, 64'd9);
    send_request(itda_pkg::OP_SIGNED,   64'd10);
    send_request(itda_pkg::OP_UNSIGNED, 64'd99);
    send_request(itda_pkg::OP_SIGNED,   64'd100);
    send_request(itda_pkg::OP_SIGNED,   {64{1'b1}});
    send_request(itda_pkg::OP_UNSIGNED, {64{1'b1}});
    send_request(itda_pkg::OP_SIGNED,   64'h8000_0000_0000_0000);
    send_request(itda_pkg::OP_UNSIGNED, 64'h8000_0000_0000_0000);
    send_request(itda_pkg::OP_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
    send_request(itda_pkg::OP_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(itda_pkg::OP_UNSIGNED, 64'd10000000000000000000);
    send_request(itda_pkg::OP_UNSIGNED, 64'd9999999999999999999);
    send_request(itda_pkg::OP_SIGNED,   -64'd10);
    send_request(itda_pkg::OP_SIGNED,   -64'd9);
    send_request(itda_pkg::OP_SIGNED,   64'd999999999999999999);
    send_request(itda_pkg::OP_SIGNED,   -64'd1000000000000000000);
    send_request(itda_pkg::OP_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(itda_pkg::OP_SIGNED,   64'h5555_5555_5555_5555);

    // Let the block run dry before the random traffic starts.
    drain_block();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 14; sink_idle_pct = 70; end
        1: begin src_idle_pct = 70; sink_idle_pct = 14; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        send_request(1'($urandom_range(1)), pick_value());
      drain_block();
    end

    $display("Converted %0d values (%0d signed, %0d negative) into %0d characters.",
             sb.values_seen, sb.signed_seen, sb.negative_seen, sb.chars_checked);
    $display("Longest text was %0d characters; %0d mismatches.",
             sb.longest_text, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
